// ----- rtl/xyp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xyp_pkg
// types and constants shared by the xy coordinate text parser
// ----------------------------------------------------------------------------
package xyp_pkg;

  localparam int VALUE_W     = 32;
  localparam int MAG_W       = VALUE_W - 1;
  localparam int FRAC_POS_W  = 3;

  // fractional digits that still carry weight
  localparam logic [FRAC_POS_W-1:0] FRAC_DIGITS = 3'd5;
  localparam logic [FRAC_POS_W-1:0] FRAC_POS_FIRST = 3'd1;

  localparam logic [7:0] CHAR_X_LO  = 8'h78;
  localparam logic [7:0] CHAR_X_UP  = 8'h58;
  localparam logic [7:0] CHAR_Y_LO  = 8'h79;
  localparam logic [7:0] CHAR_Y_UP  = 8'h59;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_line;
  } char_item_t;

  typedef struct packed {
    logic                      point_valid;
    logic signed [VALUE_W-1:0] x_value;
    logic signed [VALUE_W-1:0] y_value;
  } point_item_t;

  typedef struct packed {
    logic                  x_field_open;
    logic                  y_field_open;
    logic                  negative_seen;
    logic                  digit_seen;
    logic                  in_fraction;
    logic [MAG_W-1:0]      magnitude_acc;
    logic [FRAC_POS_W-1:0] fraction_position;
    logic [VALUE_W-1:0]    x_held;
    logic [VALUE_W-1:0]    y_held;
    logic                  x_got;
    logic                  y_got;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    x_field_open:      1'b0,
    y_field_open:      1'b0,
    negative_seen:     1'b0,
    digit_seen:        1'b0,
    in_fraction:       1'b0,
    magnitude_acc:     '0,
    fraction_position: FRAC_POS_FIRST,
    x_held:            '0,
    y_held:            '0,
    x_got:             1'b0,
    y_got:             1'b0
  };

endpackage
`default_nettype wire

// ----- rtl/xy_coordinate_text_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xy_coordinate_text_parser
// picks X and Y coordinates out of a text line, one character per item
// ----------------------------------------------------------------------------
// usage
//   the input channel carries one character per item with an end_of_line
//   flag on the last character of the line. only the last character of a
//   line produces an output item: point_valid plus X and Y in signed fixed
//   point with FRAC_BITS fraction bits, 0 for an axis that was not seen.
//   an accepted item lands in the input register; when the parse stage
//   fires, the parse logic updates the line state and, for a last
//   character, loads the output register. one character per cycle is
//   sustained unless a line result waits on a stalled receiver, the
//   combinational state update (multiply by ten plus a small fraction
//   product) being the loop that sets it.
//   when the receiver stalls with a result pending, characters keep
//   flowing until the next end-of-line character reaches the parse stage;
//   that stage then holds and the input stall rises.
//   reset empties both registers and clears the line state.
// ----------------------------------------------------------------------------
module xy_coordinate_text_parser #(
  parameter int FRAC_BITS = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  xyp_pkg::char_item_t   in_item_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output xyp_pkg::point_item_t  out_item_o
);
  import xyp_pkg::*;

  // input register
  char_item_t   in_q;
  logic         in_valid_q;

  // line state
  parse_state_t st_q;
  parse_state_t st_d;

  // output register
  point_item_t  out_q;
  point_item_t  res;
  logic         out_valid_q;
  logic         out_valid_d;

  logic         out_free;
  logic         fire;
  logic         take;

  xyp_char_step #(
    .FRAC_BITS(FRAC_BITS)
  ) u_step (
    .st_i  (st_q),
    .item_i(in_q),
    .st_o  (st_d),
    .res_o (res)
  );

  // the output register can take a result this cycle
  assign out_free = ~out_valid_q | ~out_stall_i;
  // parse stage advances unless a line result has nowhere to go
  assign fire     = in_valid_q & (~in_q.end_of_line | out_free);
  assign take     = in_valid_i & ~in_stall_o;

  assign in_stall_o  = in_valid_q & ~fire;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    if (fire && in_q.end_of_line) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q & out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= PARSE_RESET;
    end else begin
      in_valid_q  <= take | in_stall_o;
      out_valid_q <= out_valid_d;
      if (fire) begin
        st_q <= st_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= in_item_i;
    end
    if (fire && in_q.end_of_line) begin
      out_q <= res;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/xyp_char_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xyp_char_step
// next parse state and line result for one character
// ----------------------------------------------------------------------------
module xyp_char_step #(
  parameter int FRAC_BITS = 16
) (
  input  xyp_pkg::parse_state_t st_i,
  input  xyp_pkg::char_item_t   item_i,
  output xyp_pkg::parse_state_t st_o,
  output xyp_pkg::point_item_t  res_o
);
  import xyp_pkg::*;

  localparam int SUM_W = MAG_W + 5;

  // round(2^FRAC_BITS / 10^k), half up
  localparam int unsigned W1 = ((1 << (FRAC_BITS + 1)) + 10) / 20;
  localparam int unsigned W2 = ((1 << (FRAC_BITS + 1)) + 100) / 200;
  localparam int unsigned W3 = ((1 << (FRAC_BITS + 1)) + 1000) / 2000;
  localparam int unsigned W4 = ((1 << (FRAC_BITS + 1)) + 10000) / 20000;
  localparam int unsigned W5 = ((1 << (FRAC_BITS + 1)) + 100000) / 200000;

  localparam logic [SUM_W-1:0] MAG_MAX_EXT = {5'b0, {MAG_W{1'b1}}};

  logic [3:0]             digit_val;
  logic [FRAC_BITS-1:0]   weight;
  logic [FRAC_BITS+3:0]   frac_prod;
  logic [SUM_W-1:0]       mag_ext;
  logic [SUM_W-1:0]       int_sum;
  logic [SUM_W-1:0]       frac_sum;
  logic [SUM_W-1:0]       new_sum;
  logic [MAG_W-1:0]       mag_new;
  logic                   any_open;
  parse_state_t           s1;
  parse_state_t           s2;

  // closes an open field that holds digits
  function automatic parse_state_t close_field(input parse_state_t s);
    parse_state_t       r;
    logic [VALUE_W-1:0] v;
    r = s;
    v = {1'b0, s.magnitude_acc};
    if (s.negative_seen) begin
      v = -v;
    end
    if (s.digit_seen) begin
      if (s.x_field_open) begin
        r.x_held = v;
        r.x_got  = 1'b1;
      end else if (s.y_field_open) begin
        r.y_held = v;
        r.y_got  = 1'b1;
      end
      r.x_field_open      = 1'b0;
      r.y_field_open      = 1'b0;
      r.negative_seen     = 1'b0;
      r.digit_seen        = 1'b0;
      r.in_fraction       = 1'b0;
      r.magnitude_acc     = '0;
      r.fraction_position = FRAC_POS_FIRST;
    end
    return r;
  endfunction

  assign digit_val = item_i.text_char[3:0];
  assign any_open  = st_i.x_field_open | st_i.y_field_open;

  always_comb begin
    unique case (st_i.fraction_position)
      3'd1:    weight = FRAC_BITS'(W1);
      3'd2:    weight = FRAC_BITS'(W2);
      3'd3:    weight = FRAC_BITS'(W3);
      3'd4:    weight = FRAC_BITS'(W4);
      3'd5:    weight = FRAC_BITS'(W5);
      default: weight = '0;
    endcase
  end

  assign frac_prod = {{FRAC_BITS{1'b0}}, digit_val} * {4'b0, weight};
  assign mag_ext   = {5'b0, st_i.magnitude_acc};
  // times ten as two shifts
  assign int_sum   = (mag_ext << 3) + (mag_ext << 1)
                   + ({{(SUM_W-4){1'b0}}, digit_val} << FRAC_BITS);
  assign frac_sum  = mag_ext + {{(SUM_W-FRAC_BITS-4){1'b0}}, frac_prod};

  always_comb begin
    if (!st_i.in_fraction) begin
      new_sum = int_sum;
    end else if (st_i.fraction_position <= FRAC_DIGITS) begin
      new_sum = frac_sum;
    end else begin
      new_sum = mag_ext;
    end
    mag_new = (new_sum > MAG_MAX_EXT) ? {MAG_W{1'b1}} : new_sum[MAG_W-1:0];
  end

  always_comb begin
    s1 = st_i;
    case (item_i.text_char) inside
      CHAR_X_LO, CHAR_X_UP: begin
        s1.x_field_open  = 1'b1;
        s1.negative_seen = 1'b0;
      end
      CHAR_Y_LO, CHAR_Y_UP: begin
        s1.y_field_open  = 1'b1;
        s1.negative_seen = 1'b0;
      end
      CHAR_MINUS: begin
        s1.negative_seen = 1'b1;
      end
      [CHAR_ZERO:CHAR_NINE]: begin
        if (any_open) begin
          s1.magnitude_acc = mag_new;
          s1.digit_seen    = 1'b1;
          if (st_i.in_fraction && st_i.fraction_position <= FRAC_DIGITS) begin
            s1.fraction_position = st_i.fraction_position + 3'd1;
          end
        end
      end
      CHAR_DOT: begin
        if (any_open) begin
          s1.in_fraction = 1'b1;
        end
      end
      default: begin
        s1 = close_field(st_i);
      end
    endcase

    // end of line is one more separator
    s2 = close_field(s1);
    res_o.point_valid = s2.x_got & s2.y_got;
    res_o.x_value     = s2.x_held;
    res_o.y_value     = s2.y_held;
    st_o = item_i.end_of_line ? PARSE_RESET : s1;
  end

endmodule
`default_nettype wire
